/* hdl/pip_pkg.sv */
// Shared types and codes for the point-in-polygon test block.
package pip_pkg;

    // Request codes on the input channel
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Query sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_WAIT,
        ST_OUT
    } state_t;

    // Per-edge result from the edge unit
    typedef struct packed {
        logic vld;
        logic crossed;
    } edge_res_t;

endpackage

/* hdl/pip_edge_unit.sv */
// Two-stage edge evaluation unit: crossing-number test of one edge per cycle.
module pip_edge_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         edge_vld,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    output pip_pkg::edge_res_t           res
);
    import pip_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    // Stage A: range tests and differences
    logic                 vld_a_reg, pass_a_reg, vert_a_reg, dpos_a_reg;
    logic signed [DW-1:0] dx_pa_reg, dy_ba_reg, dy_pa_reg, dx_ba_reg;

    // Stage B: cross products
    logic                 vld_b_reg, pass_b_reg, vert_b_reg, dpos_b_reg;
    logic signed [PW-1:0] lhs_reg, rhs_reg;

    logic pass_a;
    logic lhs_le, lhs_ge;

    // y span, x bound; horizontal edges fail the y span
    assign pass_a = (py > ay || py > by) && (py <= ay || py <= by)
                 && (px <= ax || px <= bx);

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= edge_vld;
            vld_b_reg <= vld_a_reg;
        end
    end

    // Datapath, no reset
    always_ff @(posedge clk)
    begin
        pass_a_reg <= pass_a;
        vert_a_reg <= (ax == bx);
        dpos_a_reg <= (by > ay);
        dx_pa_reg  <= $signed({px[COORD_BITS-1], px}) - $signed({ax[COORD_BITS-1], ax});
        dy_ba_reg  <= $signed({by[COORD_BITS-1], by}) - $signed({ay[COORD_BITS-1], ay});
        dy_pa_reg  <= $signed({py[COORD_BITS-1], py}) - $signed({ay[COORD_BITS-1], ay});
        dx_ba_reg  <= $signed({bx[COORD_BITS-1], bx}) - $signed({ax[COORD_BITS-1], ax});

        pass_b_reg <= pass_a_reg;
        vert_b_reg <= vert_a_reg;
        dpos_b_reg <= dpos_a_reg;
        lhs_reg    <= PW'(dx_pa_reg) * PW'(dy_ba_reg);
        rhs_reg    <= PW'(dy_pa_reg) * PW'(dx_ba_reg);
    end

    // Exact test px <= xinters, orientation set by the sign of dy
    assign lhs_le = (lhs_reg <= rhs_reg);
    assign lhs_ge = (lhs_reg >= rhs_reg);

    assign res.vld     = vld_b_reg;
    assign res.crossed = pass_b_reg && (vert_b_reg || (dpos_b_reg ? lhs_le : lhs_ge));

endmodule

/* hdl/point_in_polygon_test.sv */
// Point-in-polygon test by crossing number over a stored vertex table.
//
// Input channel (in_valid / in_stall): req_type 0 writes coord_x/coord_y into
// the table slot vertex_index (slots at or above MAX_VERTICES are dropped) and
// gives no result. req_type 1 queries the point coord_x/coord_y.
// Output channel (out_valid / out_stall): one transfer per query carrying
// inside_res and its inverse in_collision.
// Config: cfg_wr_en / cfg_wr_data set vertex_count; write only when idle.
// Counts above MAX_VERTICES act as MAX_VERTICES.
//
// A query walks the table through one read port, reading n+1 vertices
// (n = vertex_count) one per cycle and feeding the two-stage edge unit one
// edge per cycle; out_valid rises once every edge result has come back. An
// empty polygon skips the walk and raises out_valid in the cycle after the query.
// in_stall is high from query transfer until the result is taken, so items
// are handled one at a time. A stalled result holds on the output.
// Reset clears the sequencer and vertex_count; table contents are undefined
// until written.
module point_in_polygon_test #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic                                     req_type,
    input  logic [$clog2(MAX_VERTICES)-1:0]          vertex_index,
    input  logic signed [COORD_BITS-1:0]             coord_x,
    input  logic signed [COORD_BITS-1:0]             coord_y,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic                                     inside_res,
    output logic                                     in_collision,
    input  logic                                     cfg_wr_en,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]        cfg_wr_data
);
    import pip_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    // Vertex table
    logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   iss_cnt_reg, iss_cnt_next;
    logic [CNT_W-1:0]   done_cnt_reg, done_cnt_next;
    logic               inside_reg, inside_next;
    logic               have_prev_reg, have_prev_next;
    logic               rd_vld_reg;

    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0] rdx_reg, rdy_reg;

    logic               in_xfer, wr_en, rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [CNT_W-1:0]   n_clamped;
    edge_res_t          res;

    assign in_xfer   = in_valid && !in_stall;
    assign wr_en     = in_xfer && (req_type == REQ_WRITE)
                    && ({1'b0, vertex_index} < (IDX_W+1)'(MAX_VERTICES));
    assign n_clamped = (count_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                          : count_reg;
    // Read order 0..n-1 then 0 again closes the last edge
    assign rd_addr   = (iss_cnt_reg == n_reg) ? '0 : iss_cnt_reg[IDX_W-1:0];

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[vertex_index] <= coord_x;
            mem_y[vertex_index] <= coord_y;
        end
        if (rd_en)
        begin
            rdx_reg <= mem_x[rd_addr];
            rdy_reg <= mem_y[rd_addr];
        end
    end

    // Query point and previous vertex
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (rd_vld_reg)
        begin
            prev_x_reg <= rdx_reg;
            prev_y_reg <= rdy_reg;
        end
    end

    // Shared edge unit
    pip_edge_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .clk      (clk),
        .rst_n    (rst_n),
        .edge_vld (rd_vld_reg && have_prev_reg),
        .ax       (prev_x_reg),
        .ay       (prev_y_reg),
        .bx       (rdx_reg),
        .by       (rdy_reg),
        .px       (px_reg),
        .py       (py_reg),
        .res      (res)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            iss_cnt_reg   <= '0;
            done_cnt_reg  <= '0;
            inside_reg    <= 1'b0;
            have_prev_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
            state_reg     <= state_next;
            n_reg         <= n_next;
            iss_cnt_reg   <= iss_cnt_next;
            done_cnt_reg  <= done_cnt_next;
            inside_reg    <= inside_next;
            have_prev_reg <= have_prev_next;
            rd_vld_reg    <= rd_en;
        end
    end

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        iss_cnt_next   = iss_cnt_reg;
        done_cnt_next  = done_cnt_reg;
        inside_next    = inside_reg;
        have_prev_next = have_prev_reg;
        rd_en          = 1'b0;

        // Edge results and returning reads
        if (res.vld)
        begin
            done_cnt_next = done_cnt_reg + 1'b1;
            inside_next   = inside_reg ^ res.crossed;
        end
        if (rd_vld_reg)
        begin
            have_prev_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (req_type == REQ_QUERY))
                begin
                    n_next         = n_clamped;
                    iss_cnt_next   = '0;
                    done_cnt_next  = '0;
                    inside_next    = 1'b0;
                    have_prev_next = 1'b0;
                    state_next     = (n_clamped == '0) ? ST_OUT : ST_WALK;
                end
            end
            ST_WALK:
            begin
                rd_en = 1'b1;
                if (iss_cnt_reg == n_reg)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    iss_cnt_next = iss_cnt_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (done_cnt_reg == n_reg)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = (state_reg == ST_OUT);
    assign inside_res   = inside_reg;
    assign in_collision = ~inside_reg;

    // Edge results arrive only during a walk or the wait after it
    a_res_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        res.vld |-> (state_reg == ST_WALK || state_reg == ST_WAIT))
        else $error("edge result outside a query walk");

    // Never more edges than vertices
    a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_cnt_reg <= n_reg)
        else $error("edge count overran vertex count");

    // Read issue never passes the closing read
    a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
        iss_cnt_reg <= n_reg)
        else $error("read issue counter overran");

    // A query always leaves idle
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (req_type == REQ_QUERY)) |=> (state_reg != ST_IDLE))
        else $error("query transfer did not start the sequencer");

    // Result held steady under stall
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(inside_reg)))
        else $error("stalled result changed");

endmodule

/* sim/tb_point_in_polygon_test.sv */
// Self-checking testbench for the point-in-polygon crossing-number block.
`timescale 1ns / 1ps

module tb_point_in_polygon_test;

    import pip_pkg::*;

    localparam int MAX_VERT       = 64;
    localparam int COORD_W        = 16;
    localparam int ITEM_TARGET    = 800;
    localparam int MAX_WAIT       = 11;
    localparam int HOLD_CYCLES    = 400;
    localparam int LAT_PAUSE      = 80;   // settling pause before a count change and at the end
    localparam int WATCHDOG_LIMIT = 3000;

    // Coordinate styles for random vertices and points
    localparam int CM_FULL = 0;   // anywhere in the signed range
    localparam int CM_GRID = 1;   // coarse grid, lots of equal coordinates
    localparam int CM_EDGE = 2;   // values at and next to the range limits and zero

    typedef enum int {
        ROW_CFG,
        ROW_WRITE,
        ROW_QUERY
    } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [5:0]           idx;
        logic signed [15:0]   x;
        logic signed [15:0]   y;
        logic [6:0]           cnt;
        bit                   pinned;
        bit                   pinned_inside;
    } stim_row_t;

    typedef struct packed {
        logic is_in;
        logic collision;
    } verdict_t;

    // DUT signals, all driven to known values from time zero
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       req_type = REQ_WRITE;
    logic [5:0]                 vertex_index = '0;
    logic signed [COORD_W-1:0]  coord_x = '0;
    logic signed [COORD_W-1:0]  coord_y = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       inside_res;
    logic                       in_collision;
    logic                       cfg_wr_en = 1'b0;
    logic [6:0]                 cfg_wr_data = '0;

    // Shadow copy of the polygon
    logic signed [COORD_W-1:0]  poly_x [MAX_VERT];
    logic signed [COORD_W-1:0]  poly_y [MAX_VERT];
    logic [6:0]                 poly_count = '0;

    verdict_t   pending_verdicts [$];
    stim_row_t  dir_rows [$];
    int         mismatches = 0;
    int         idle_cycles = 0;
    int         items_sent = 0;
    bit         tx_idle = 1'b1;
    bit         rx_idle = 1'b1;
    bit         hold_req = 1'b0;
    bit         pin_en = 1'b0;
    bit         pin_inside = 1'b0;
    bit         moved;
    verdict_t   got_v;
    verdict_t   exp_v;

    point_in_polygon_test #(
        .MAX_VERTICES (MAX_VERT),
        .COORD_BITS   (COORD_W)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .inside_res   (inside_res),
        .in_collision (in_collision),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One edge of the crossing-number rule; products stay well inside 64 bits
    function automatic bit edge_hit(longint px, longint py, longint ax, longint ay,
                                    longint bx, longint by);
        longint d;
        longint lhs;
        longint rhs;
        if (!(py > ay || py > by))
            return 1'b0;
        if (!(py <= ay || py <= by))
            return 1'b0;
        if (!(px <= ax || px <= bx))
            return 1'b0;
        if (ax == bx)
            return 1'b1;
        d   = by - ay;
        lhs = (px - ax) * d;
        rhs = (py - ay) * (bx - ax);
        return (d > 0) ? (lhs <= rhs) : (lhs >= rhs);
    endfunction

    // Parity of ray crossings over all edges in use
    function automatic bit ray_parity(logic signed [COORD_W-1:0] px,
                                      logic signed [COORD_W-1:0] py);
        int n;
        int i;
        int j;
        bit is_in;
        n = (poly_count > MAX_VERT) ? MAX_VERT : int'(poly_count);
        is_in = 1'b0;
        for (i = 0; i < n; i++)
        begin
            j = (i + 1 == n) ? 0 : i + 1;
            if (edge_hit(px, py, poly_x[i], poly_y[i], poly_x[j], poly_y[j]))
                is_in = !is_in;
        end
        return is_in;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
        int v;
        case (mode)
            CM_GRID: v = (int'($urandom_range(0, 12)) - 6) * 4096;
            CM_EDGE:
            begin
                case ($urandom_range(0, 6))
                    0: v = -32768;
                    1: v = -32767;
                    2: v = -1;
                    3: v = 0;
                    4: v = 1;
                    5: v = 32766;
                    default: v = 32767;
                endcase
            end
            default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        return v[COORD_W-1:0];
    endfunction

    task automatic add_row(row_kind_t kind, logic [5:0] idx, logic signed [15:0] x,
                           logic signed [15:0] y, logic [6:0] cnt, bit pinned,
                           bit pinned_inside);
        stim_row_t r;
        r.kind          = kind;
        r.idx           = idx;
        r.x             = x;
        r.y             = y;
        r.cnt           = cnt;
        r.pinned        = pinned;
        r.pinned_inside = pinned_inside;
        dir_rows = {dir_rows, r};
    endtask

    // Offer one item, after a random gap when tx_idle is set, and hold it until the transfer
    task automatic send_item(logic req, logic [5:0] idx, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y, bit pinned, bit pinned_inside);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pin_en       = pinned;
        pin_inside   = pinned_inside;
        in_valid     <= 1'b1;
        req_type     <= req;
        vertex_index <= idx;
        coord_x      <= x;
        coord_y      <= y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Stop offering and wait until every predicted verdict has come back
    task automatic wait_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
    endtask

    // Change vertex_count only once the block has gone quiet
    task automatic set_count(logic [6:0] v);
        wait_results();
        repeat (LAT_PAUSE) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One random polygon: set the count, write its vertices, then query it
    task automatic run_phase(int phase_no);
        logic [6:0]                 v;
        int                         n;
        int                         mode;
        int                         nq;
        int                         k;
        int                         q;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        case ($urandom_range(0, 19))
            0: v = 7'd0;
            1: v = 7'd1;
            2: v = 7'd2;
            3: v = 7'd64;
            4: v = $urandom_range(0, 1) ? 7'd127 : 7'($urandom_range(65, 126));
            default: v = 7'($urandom_range(3, 12));
        endcase
        n       = (v > MAX_VERT) ? MAX_VERT : int'(v);
        mode    = $urandom_range(CM_FULL, CM_EDGE);
        tx_idle = ($urandom_range(0, 4) != 0);
        rx_idle = ($urandom_range(0, 4) != 0);
        set_count(v);

        // every slot below n gets written before the first query
        for (k = 0; k < n; k++)
        begin
            send_item(REQ_WRITE, k[5:0], rand_coord(mode), rand_coord(mode), 1'b0, 1'b0);
            if ($urandom_range(0, 7) == 0)
                send_item(REQ_WRITE, 6'($urandom_range(0, 63)), rand_coord(mode),
                          rand_coord(mode), 1'b0, 1'b0);
        end

        if (phase_no == 0 || $urandom_range(0, 4) == 0)
            hold_req = 1'b1;

        nq = $urandom_range(8, 20);
        for (q = 0; q < nq; q++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(REQ_WRITE, 6'($urandom_range(0, 63)), rand_coord(mode),
                          rand_coord(mode), 1'b0, 1'b0);
            if ($urandom_range(0, 14) == 0)
                wait_results();
            px = rand_coord(mode);
            py = rand_coord(mode);
            // points sharing a coordinate with a vertex hit the tie cases
            if (n > 0 && $urandom_range(0, 2) == 0)
            begin
                k = $urandom_range(0, n - 1);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        px = poly_x[k];
                        py = poly_y[k];
                    end
                    1: py = poly_y[k];
                    default: px = poly_x[k];
                endcase
            end
            send_item(REQ_QUERY, 6'($urandom_range(0, 63)), px, py, 1'b0, 1'b0);
        end
    endtask

    // Result receiver: random stall per result, one long hold on request
    initial
    begin : result_sink
        int w;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                w = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                w = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // Transfer monitor: checks results, updates the shadow state, feeds the watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                got_v = '{is_in: inside_res, collision: in_collision};
                if (pending_verdicts.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, actual inside=%0b coll=%0b",
                             $time, inside_res, in_collision);
                end
                else
                begin
                    exp_v = pending_verdicts.pop_front();
                    if (got_v.is_in !== exp_v.is_in)
                    begin
                        mismatches++;
                        $display("%0t: inside_res mismatch: expected %0b, actual %0b",
                                 $time, exp_v.is_in, got_v.is_in);
                    end
                    if (got_v.collision !== exp_v.collision)
                    begin
                        mismatches++;
                        $display("%0t: in_collision mismatch: expected %0b, actual %0b",
                                 $time, exp_v.collision, got_v.collision);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                if (req_type == REQ_WRITE)
                begin
                    poly_x[vertex_index] = coord_x;
                    poly_y[vertex_index] = coord_y;
                end
                else
                begin
                    exp_v.is_in = pin_en ? pin_inside : ray_parity(coord_x, coord_y);
                    exp_v.collision = !exp_v.is_in;
                    pending_verdicts = {pending_verdicts, exp_v};
                end
            end
            if (cfg_wr_en)
            begin
                moved = 1'b1;
                poly_count = cfg_wr_data;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on cycles without any transfer
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(negedge clk);
        $display("tb_point_in_polygon_test: FAIL");
        $finish;
    end

    // Main sequence
    initial
    begin : stimulus
        int phase_no;

        // empty polygon straight after reset: always outside
        add_row(ROW_CFG,   0, 0, 0, 7'd0, 0, 0);
        add_row(ROW_QUERY, 0, 0, 0, 0, 1, 0);
        add_row(ROW_QUERY, 0, -32768, -32768, 0, 1, 0);
        add_row(ROW_QUERY, 0, 32767, 32767, 0, 1, 0);
        // single vertex: degenerate edge never toggles
        add_row(ROW_WRITE, 0, 4096, 4096, 0, 0, 0);
        add_row(ROW_CFG,   0, 0, 0, 7'd1, 0, 0);
        add_row(ROW_QUERY, 0, 4096, 4096, 0, 1, 0);
        add_row(ROW_QUERY, 0, 4096, 8192, 0, 1, 0);
        // two vertices: edge and its reverse
        add_row(ROW_WRITE, 0, -4096, -4096, 0, 0, 0);
        add_row(ROW_WRITE, 1, 4096, -4096, 0, 0, 0);
        add_row(ROW_CFG,   0, 0, 0, 7'd2, 0, 0);
        add_row(ROW_QUERY, 0, 0, 0, 0, 0, 0);
        // square of side 8192: center, corner and points on its sides
        add_row(ROW_WRITE, 2, 4096, 4096, 0, 0, 0);
        add_row(ROW_WRITE, 3, -4096, 4096, 0, 0, 0);
        add_row(ROW_CFG,   0, 0, 0, 7'd4, 0, 0);
        add_row(ROW_QUERY, 0, 0, 0, 0, 0, 0);
        add_row(ROW_QUERY, 0, -4096, -4096, 0, 0, 0);
        add_row(ROW_QUERY, 0, 4096, 0, 0, 0, 0);
        add_row(ROW_QUERY, 0, -4096, 0, 0, 0, 0);
        add_row(ROW_QUERY, 0, 0, 4096, 0, 0, 0);
        // full-range triangle, queried at the origin, the range corners and a point on its base
        add_row(ROW_WRITE, 0, -32768, -32768, 0, 0, 0);
        add_row(ROW_WRITE, 1, 32767, -32768, 0, 0, 0);
        add_row(ROW_WRITE, 2, 0, 32767, 0, 0, 0);
        add_row(ROW_CFG,   0, 0, 0, 7'd3, 0, 0);
        add_row(ROW_QUERY, 0, 0, 0, 0, 0, 0);
        add_row(ROW_QUERY, 0, 32767, 32767, 0, 0, 0);
        add_row(ROW_QUERY, 0, -32768, 32767, 0, 0, 0);
        add_row(ROW_QUERY, 0, 0, -32768, 0, 0, 0);
        add_row(ROW_QUERY, 0, 32767, -32768, 0, 0, 0);
        add_row(ROW_WRITE, 63, 32767, -1, 0, 0, 0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[r])
        begin
            case (dir_rows[r].kind)
                ROW_CFG:   set_count(dir_rows[r].cnt);
                ROW_WRITE: send_item(REQ_WRITE, dir_rows[r].idx, dir_rows[r].x,
                                     dir_rows[r].y, 1'b0, 1'b0);
                default:   send_item(REQ_QUERY, 6'($urandom_range(0, 63)), dir_rows[r].x,
                                     dir_rows[r].y, dir_rows[r].pinned,
                                     dir_rows[r].pinned_inside);
            endcase
        end

        // random polygons
        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            run_phase(phase_no);
            phase_no++;
        end

        wait_results();
        repeat (LAT_PAUSE) @(posedge clk);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("tb_point_in_polygon_test: PASS");
        else
            $display("tb_point_in_polygon_test: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hdl/pip_pkg.sv
hdl/pip_edge_unit.sv
hdl/point_in_polygon_test.sv
sim/tb_point_in_polygon_test.sv
